FILE: rtl/core/first_fit_aligned_allocator_defines.svh
// Assertion macros shared by the allocator checker.
// No dependencies; take in with `include before use.
`ifndef FIRST_FIT_ALIGNED_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_ALIGNED_ALLOCATOR_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define FFAA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Consequent holds in the cycle after the antecedent.
`define FFAA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

FILE: rtl/core/ffaa_pkg.sv
// Package for the first-fit aligned allocator: table entry type and status codes.
// No dependencies.
`default_nettype none
package ffaa_pkg;
    typedef struct packed {
        logic [31:0] offset;
        logic [31:0] size;
        logic        is_free;
    } t_entry;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE = 3'd1;
    localparam logic [2:0] ST_NO_FIT    = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
endpackage
`default_nettype wire

FILE: rtl/core/ffaa_table.sv
// Block table memory: one write port, one read port, registered read data.
// Depends on ffaa_pkg.
`default_nettype none
module ffaa_table #(
    parameter int DEPTH = 64
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire ffaa_pkg::t_entry     i_wdata,
    input  wire                       i_re,
    input  wire [$clog2(DEPTH)-1:0]   i_raddr,
    output ffaa_pkg::t_entry          o_rdata
);
    ffaa_pkg::t_entry mem [DEPTH];
    ffaa_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

FILE: rtl/core/ffaa_divider.sv
// Restoring remainder unit, one quotient bit per cycle.
// No dependencies; divisor must be nonzero.
`default_nettype none
module ffaa_divider (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_start,
    input  wire [31:0] i_dividend,
    input  wire [31:0] i_divisor,
    output logic       o_done,
    output logic [31:0] o_rem
);
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_dvd;
    logic [31:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] shifted;

    always_comb begin
        shifted = {r_rem[31:0], r_dvd[31]};
        n_rem   = (shifted >= {1'b0, r_dvs}) ? shifted - {1'b0, r_dvs} : shifted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[30:0], 1'b0};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[31:0];
endmodule
`default_nettype wire

FILE: rtl/core/first_fit_aligned_allocator.sv
// First-fit aligned allocator over one chunk: sequencer, table memory, remainder unit.
// Depends on ffaa_pkg, ffaa_table, ffaa_divider.
//
// One item is handled at a time. A free item walks the table entry by entry
// (read, then compare); an allocate item reads each used entry and, for each free
// entry, waits on the bit-serial remainder (offset mod alignment), then checks
// the fit and may split the entry. After reset or a chunk_size write, the
// S_INIT state rebuilds entry 0 before items are taken.
`default_nettype none
module first_fit_aligned_allocator #(
    parameter int MAX_BLOCKS = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [95:0]  s_axis_tdata,   // req_size, req_alignment, free_offset
    input  wire         s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // block_offset, block_size
    output logic [2:0]  m_axis_tuser,   // status
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [31:0]  i_cfg_data
);
    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_WAIT  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_SPLIT = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    logic [3:0]  r_state;
    logic [31:0] r_chunk;
    logic        r_mode;
    logic [31:0] r_size, r_align, r_foff;
    logic [CW-1:0] r_idx, r_count;
    ffaa_pkg::t_entry r_ent;
    logic [31:0] r_pad, r_aoff, r_avail;
    logic [2:0]  r_status;
    logic [31:0] r_res_off, r_res_size;
    logic        r_out_valid;
    logic [2:0]  r_out_status;
    logic [31:0] r_out_off, r_out_size;

    logic             we, re;
    logic [AW-1:0]    waddr;
    ffaa_pkg::t_entry wdata, rdata;
    logic             div_start, div_done;
    logic [31:0]      div_rem;
    logic [31:0]      aoff, avail;
    logic             in_fire, out_fire;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign aoff  = r_ent.offset + r_pad;
    assign avail = r_ent.size - r_pad;
    assign re    = (r_state == S_RD) && (r_idx < r_count);
    assign div_start = (r_state == S_WAIT) && !r_mode && rdata.is_free;

    always_comb begin
        we    = 1'b0;
        waddr = r_idx[AW-1:0];
        wdata = '{offset: aoff, size: r_size, is_free: 1'b0};
        case (r_state)
            S_INIT: begin
                we    = 1'b1;
                waddr = '0;
                wdata = '{offset: 32'd0, size: r_chunk, is_free: 1'b1};
            end
            S_WAIT: begin
                we    = r_mode && !rdata.is_free && rdata.offset == r_foff &&
                        rdata.size == r_size;
                wdata = '{offset: rdata.offset, size: rdata.size, is_free: 1'b1};
            end
            S_CHK: begin
                we = (r_pad <= r_ent.size) && (avail >= r_size) &&
                     ((avail == r_size) || (r_count < MAXC));
            end
            S_SPLIT: begin
                we    = 1'b1;
                waddr = r_count[AW-1:0];
                wdata = '{offset: r_aoff + r_size, size: r_avail - r_size, is_free: 1'b1};
            end
            default: we = 1'b0;
        endcase
    end

    ffaa_table #(.DEPTH(MAX_BLOCKS)) u_table (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_re(re), .i_raddr(r_idx[AW-1:0]), .o_rdata(rdata)
    );

    ffaa_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(rdata.offset), .i_divisor(r_align),
        .o_done(div_done), .o_rem(div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_chunk     <= 32'd65536;
            r_count     <= CW'(1);
            r_out_valid <= 1'b0;
        end else begin
            // in S_DONE the reload below decides the valid flag
            if (out_fire && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_count <= CW'(1);
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        r_chunk <= i_cfg_data;
                        r_state <= S_INIT;
                    end else if (in_fire) begin
                        r_mode  <= s_axis_tuser;
                        r_size  <= s_axis_tdata[31:0];
                        r_align <= (s_axis_tdata[63:32] == 32'd0) ? 32'd1 : s_axis_tdata[63:32];
                        r_foff  <= s_axis_tdata[95:64];
                        r_idx   <= '0;
                        if (!s_axis_tuser && s_axis_tdata[31:0] > r_chunk) begin
                            r_status   <= ffaa_pkg::ST_TOO_LARGE;
                            r_res_off  <= '0;
                            r_res_size <= '0;
                            r_state    <= S_DONE;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    if (r_idx < r_count) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_status   <= r_mode ? ffaa_pkg::ST_NOT_FOUND : ffaa_pkg::ST_NO_FIT;
                        r_res_off  <= r_mode ? r_foff : 32'd0;
                        r_res_size <= r_mode ? r_size : 32'd0;
                        r_state    <= S_DONE;
                    end
                end
                S_WAIT: begin
                    r_ent <= rdata;
                    if (we) begin
                        r_status   <= ffaa_pkg::ST_OK;
                        r_res_off  <= r_foff;
                        r_res_size <= r_size;
                        r_state    <= S_DONE;
                    end else if (div_start) begin
                        r_state <= S_DIV;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_RD;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_pad   <= (div_rem != 32'd0) ? r_align - div_rem : 32'd0;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_aoff  <= aoff;
                    r_avail <= avail;
                    if (r_pad > r_ent.size || avail < r_size) begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_RD;
                    end else if (avail == r_size) begin
                        r_status   <= ffaa_pkg::ST_OK;
                        r_res_off  <= aoff;
                        r_res_size <= r_size;
                        r_state    <= S_DONE;
                    end else if (r_count >= MAXC) begin
                        r_status   <= ffaa_pkg::ST_FULL;
                        r_res_off  <= '0;
                        r_res_size <= '0;
                        r_state    <= S_DONE;
                    end else begin
                        r_status   <= ffaa_pkg::ST_OK;
                        r_res_off  <= aoff;
                        r_res_size <= r_size;
                        r_state    <= S_SPLIT;
                    end
                end
                S_SPLIT: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // result register frees up on the same cycle it is taken
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_off    <= r_res_off;
                        r_out_size   <= r_res_size;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_INIT;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_size, r_out_off};
    assign m_axis_tuser  = r_out_status;
endmodule
`default_nettype wire

FILE: rtl/core/ffaa_checker.sv
// Port-level checker for the allocator, bound to the top level.
// Depends on ffaa_pkg and first_fit_aligned_allocator_defines.svh.
`default_nettype none
`include "first_fit_aligned_allocator_defines.svh"
module ffaa_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [63:0] m_axis_tdata,
    input wire [2:0]  m_axis_tuser
);
    `FFAA_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `FFAA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `FFAA_ASSERT_SAME(a_err_zero, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == ffaa_pkg::ST_TOO_LARGE || m_axis_tuser == ffaa_pkg::ST_NO_FIT || m_axis_tuser == ffaa_pkg::ST_FULL), m_axis_tdata == 64'd0)
endmodule

bind first_fit_aligned_allocator ffaa_checker u_ffaa_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire
